>>> rtl/bresenham_span_rasterizer_assert.svh
// Assertion macros for the span rasterizer
`ifndef BRESENHAM_SPAN_RASTERIZER_ASSERT_SVH
`define BRESENHAM_SPAN_RASTERIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define BSR_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define BSR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define BSR_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg)
`define BSR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

>>> rtl/bsr_pkg.sv
// Shared constants, codes and helpers of the span rasterizer
package bsr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int DIM_BITS_DEF   = 12;
  localparam int VALUE_BITS     = 8;
  localparam int CFG_BITS       = 13;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_BITS-1:0] DIM_RESET = 13'd4096;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PULL  = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic {
    WS_IDLE,
    WS_WALK
  } walk_state_t;

  // kind, steep, three direction flags, three positions, two deltas, fill
  function automatic int cmd_bits(int cb);
    return 5 + 3 * (cb + 1) + 2 * cb + VALUE_BITS;
  endfunction

  function automatic int byte_pad(int b);
    return ((b + 7) / 8) * 8;
  endfunction

endpackage

>>> rtl/bsr_front.sv
// Front end: classifies transactions and sets up octant, deltas and directions
module bsr_front #(
  parameter int COORD_BITS = bsr_pkg::COORD_BITS_DEF
) (
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_op,
  input  logic signed [COORD_BITS-1:0]             in_start_x,
  input  logic signed [COORD_BITS-1:0]             in_start_y,
  input  logic signed [COORD_BITS-1:0]             in_end_x,
  input  logic signed [COORD_BITS-1:0]             in_end_y,
  input  logic [bsr_pkg::VALUE_BITS-1:0]           in_fill,
  output logic                                     q_valid,
  input  logic                                     q_ready,
  output logic [bsr_pkg::cmd_bits(COORD_BITS)-1:0] q_data
);

  localparam int CW = COORD_BITS + 1;

  typedef struct packed {
    logic                            kind;
    logic                            steep;
    logic                            maj_neg;
    logic                            min_neg;
    logic                            min_nz;
    logic signed [CW-1:0]            major_pos;
    logic signed [CW-1:0]            minor_pos;
    logic signed [CW-1:0]            major_end;
    logic [COORD_BITS-1:0]           dmaj;
    logic [COORD_BITS-1:0]           dmin;
    logic [bsr_pkg::VALUE_BITS-1:0]  fill;
  } cmd_t;

  logic signed [CW-1:0]  x0, y0, x1, y1, dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  steep;
  cmd_t                  cmd;

  always_comb begin
    x0  = CW'(in_start_x);
    y0  = CW'(in_start_y);
    x1  = CW'(in_end_x);
    y1  = CW'(in_end_y);
    dx  = x1 - x0;
    dy  = y1 - y0;
    ndx = -dx;
    ndy = -dy;
    adx = dx[CW-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady = dy[CW-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    steep = ady > adx;

    cmd.kind      = in_op;
    cmd.steep     = steep;
    cmd.maj_neg   = steep ? dy[CW-1] : dx[CW-1];
    cmd.min_neg   = steep ? dx[CW-1] : dy[CW-1];
    cmd.min_nz    = steep ? (|dx) : (|dy);
    cmd.major_pos = steep ? y0 : x0;
    cmd.minor_pos = steep ? x0 : y0;
    cmd.major_end = steep ? y1 : x1;
    cmd.dmaj      = steep ? ady : adx;
    cmd.dmin      = steep ? adx : ady;
    cmd.fill      = in_fill;
  end

  assign q_valid  = in_valid;
  assign in_ready = q_ready;
  assign q_data   = cmd;

endmodule

>>> rtl/bsr_fifo.sv
// Short command queue between the front end and the walker
module bsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bsr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [WIDTH-1:0] m_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             push, pop;

  assign s_ready = count_r != (PW + 1)'(DEPTH);
  assign m_valid = count_r != '0;
  assign m_data  = mem_r[rd_ptr_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= s_data;
    end
  end

endmodule

>>> rtl/bsr_walk.sv
// Back end: steps a pixel per cycle unless out stalls; registers clipped spans
module bsr_walk #(
  parameter int COORD_BITS = bsr_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS   = bsr_pkg::DIM_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  output logic                                     q_ready,
  input  logic [bsr_pkg::cmd_bits(COORD_BITS)-1:0] q_data,
  input  logic [bsr_pkg::CFG_BITS-1:0]             img_width,
  input  logic [bsr_pkg::CFG_BITS-1:0]             img_height,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [DIM_BITS-1:0]                      out_row,
  output logic [DIM_BITS-1:0]                      out_first,
  output logic [DIM_BITS-1:0]                      out_final,
  output logic                                     out_span_valid,
  output logic                                     out_done,
  output logic [bsr_pkg::VALUE_BITS-1:0]           out_value
);

  localparam int CW   = COORD_BITS + 1;
  localparam int ERRW = COORD_BITS + 3;
  localparam int EW   = (bsr_pkg::CFG_BITS > DIM_BITS + 1) ? bsr_pkg::CFG_BITS : DIM_BITS + 1;
  localparam int KW   = ((CW > DIM_BITS + 2) ? CW : DIM_BITS + 2) + 1;
  localparam logic [EW-1:0] DIM_LIM = EW'(1 << DIM_BITS);

  typedef struct packed {
    logic                            kind;
    logic                            steep;
    logic                            maj_neg;
    logic                            min_neg;
    logic                            min_nz;
    logic signed [CW-1:0]            major_pos;
    logic signed [CW-1:0]            minor_pos;
    logic signed [CW-1:0]            major_end;
    logic [COORD_BITS-1:0]           dmaj;
    logic [COORD_BITS-1:0]           dmin;
    logic [bsr_pkg::VALUE_BITS-1:0]  fill;
  } cmd_t;

  typedef struct packed {
    logic                            active;
    logic                            steep;
    logic                            maj_neg;
    logic                            min_neg;
    logic                            min_nz;
    logic signed [CW-1:0]            major_pos;
    logic signed [CW-1:0]            minor_pos;
    logic signed [CW-1:0]            major_end;
    logic signed [ERRW-1:0]          err;
    logic signed [ERRW-1:0]          straight;
    logic signed [ERRW-1:0]          diag;
    logic signed [CW-1:0]            run_x;
    logic signed [CW-1:0]            run_row;
    logic [bsr_pkg::VALUE_BITS-1:0]  held;
  } walk_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]             row;
    logic [DIM_BITS-1:0]             first;
    logic [DIM_BITS-1:0]             final_x;
    logic                            ok;
    logic                            done;
    logic [bsr_pkg::VALUE_BITS-1:0]  value;
  } res_t;

  typedef struct packed {
    logic load;
    logic null_res;
    logic step;
    logic emit;
    logic emit_done;
  } ctl_t;

  cmd_t                 cmd;
  walk_t                walk_r, walk_nxt;
  res_t                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bsr_pkg::walk_state_t state_r, state_nxt;
  ctl_t                 ctl;

  logic                 can_emit, at_end, err_neg, row_chg;
  logic signed [CW-1:0] one_c, maj_stepped, min_stepped, last_x, lo, hi;
  logic signed [KW-1:0] lo_k, hi_k, y_k, w_k, h_k, lo_c, hi_c;
  logic [EW-1:0]        w_full, h_full, w_eff, h_eff;
  logic                 ok;
  logic [ERRW-1:0]      two_dmin, two_dmaj;

  assign cmd      = cmd_t'(q_data);
  assign can_emit = !out_valid_r || out_ready;
  assign at_end   = walk_r.major_pos == walk_r.major_end;
  assign err_neg  = walk_r.err[ERRW-1];
  // a steep line changes row on every step, a flat one only on a diagonal move
  assign row_chg  = walk_r.steep || (!err_neg && walk_r.min_nz);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsr_pkg::WS_IDLE: begin
        if (q_valid && cmd.kind == bsr_pkg::OP_PULL && walk_r.active) begin
          state_nxt = bsr_pkg::WS_WALK;
        end
      end
      bsr_pkg::WS_WALK: begin
        if ((at_end || row_chg) && can_emit) begin
          state_nxt = bsr_pkg::WS_IDLE;
        end
      end
      default: state_nxt = bsr_pkg::WS_IDLE;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    ctl     = '0;
    case (state_r)
      bsr_pkg::WS_IDLE: begin
        q_ready      = (cmd.kind == bsr_pkg::OP_START) || walk_r.active || can_emit;
        ctl.load     = q_valid && q_ready && cmd.kind == bsr_pkg::OP_START;
        ctl.null_res = q_valid && q_ready && cmd.kind == bsr_pkg::OP_PULL && !walk_r.active;
      end
      bsr_pkg::WS_WALK: begin
        if (at_end) begin
          ctl.emit      = can_emit;
          ctl.emit_done = 1'b1;
        end else if (row_chg) begin
          ctl.step = can_emit;
          ctl.emit = can_emit;
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    one_c       = CW'(1);
    maj_stepped = walk_r.maj_neg ? walk_r.major_pos - one_c : walk_r.major_pos + one_c;
    min_stepped = walk_r.minor_pos;
    if (!err_neg && walk_r.min_nz) begin
      min_stepped = walk_r.min_neg ? walk_r.minor_pos - one_c : walk_r.minor_pos + one_c;
    end
    two_dmin = {2'b00, cmd.dmin, 1'b0};
    two_dmaj = {2'b00, cmd.dmaj, 1'b0};

    walk_nxt = walk_r;
    if (ctl.load) begin
      walk_nxt.active    = 1'b1;
      walk_nxt.steep     = cmd.steep;
      walk_nxt.maj_neg   = cmd.maj_neg;
      walk_nxt.min_neg   = cmd.min_neg;
      walk_nxt.min_nz    = cmd.min_nz;
      walk_nxt.major_pos = cmd.major_pos;
      walk_nxt.minor_pos = cmd.minor_pos;
      walk_nxt.major_end = cmd.major_end;
      walk_nxt.err       = two_dmin - {3'b000, cmd.dmaj};
      walk_nxt.straight  = two_dmin;
      walk_nxt.diag      = two_dmin - two_dmaj;
      walk_nxt.run_x     = cmd.steep ? cmd.minor_pos : cmd.major_pos;
      walk_nxt.run_row   = cmd.steep ? cmd.major_pos : cmd.minor_pos;
      walk_nxt.held      = cmd.fill;
    end
    if (ctl.step) begin
      walk_nxt.major_pos = maj_stepped;
      walk_nxt.minor_pos = min_stepped;
      walk_nxt.err       = err_neg ? walk_r.err + walk_r.straight : walk_r.err + walk_r.diag;
      if (ctl.emit) begin
        walk_nxt.run_x   = walk_r.steep ? min_stepped : maj_stepped;
        walk_nxt.run_row = walk_r.steep ? maj_stepped : min_stepped;
      end
    end
    if (ctl.emit && ctl.emit_done) begin
      walk_nxt.active = 1'b0;
    end
  end

  // span clipping, all from registered walker state
  always_comb begin
    last_x = walk_r.steep ? walk_r.minor_pos : walk_r.major_pos;
    lo     = (walk_r.run_x < last_x) ? walk_r.run_x : last_x;
    hi     = (walk_r.run_x < last_x) ? last_x : walk_r.run_x;
    w_full = EW'(img_width);
    h_full = EW'(img_height);
    w_eff  = (w_full > DIM_LIM) ? DIM_LIM : w_full;
    h_eff  = (h_full > DIM_LIM) ? DIM_LIM : h_full;
    lo_k   = KW'(lo);
    hi_k   = KW'(hi);
    y_k    = KW'(walk_r.run_row);
    w_k    = KW'(w_eff[DIM_BITS:0]);
    h_k    = KW'(h_eff[DIM_BITS:0]);
    ok     = !(hi_k[KW-1] || lo_k >= w_k || y_k[KW-1] || y_k >= h_k);
    lo_c   = lo_k[KW-1] ? '0 : lo_k;
    hi_c   = (hi_k >= w_k) ? w_k - KW'(1) : hi_k;
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.emit) begin
      res_nxt.row     = ok ? y_k[DIM_BITS-1:0] : '0;
      res_nxt.first   = ok ? lo_c[DIM_BITS-1:0] : '0;
      res_nxt.final_x = ok ? hi_c[DIM_BITS-1:0] : '0;
      res_nxt.ok      = ok;
      res_nxt.done    = ctl.emit_done;
      res_nxt.value   = walk_r.held;
      out_valid_nxt   = 1'b1;
    end else if (ctl.null_res) begin
      res_nxt       = '0;
      res_nxt.done  = 1'b1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsr_pkg::WS_IDLE;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_row        = res_r.row;
  assign out_first      = res_r.first;
  assign out_final      = res_r.final_x;
  assign out_span_valid = res_r.ok;
  assign out_done       = res_r.done;
  assign out_value      = res_r.value;

endmodule

>>> rtl/bresenham_span_rasterizer.sv
// A pull transaction returns the span of the current row run once the walker has stepped
// through it; a start transaction loads the line and returns nothing. The walker takes
// the next pull only after the span of the last one is registered; a two-entry command
// queue lets the input side run ahead of the walker.
// Reset (synchronous, rst_n low): queue emptied, no line loaded, output register
// empty, image_width and image_height back to 4096.
`include "bresenham_span_rasterizer_assert.svh"

module bresenham_span_rasterizer #(
  parameter int COORD_BITS = bsr_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS   = bsr_pkg::DIM_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_tvalid,
  output logic                                                in_tready,
  // start_x, start_y, end_x, end_y, fill_value
  input  logic [bsr_pkg::byte_pad(4*COORD_BITS+bsr_pkg::VALUE_BITS)-1:0] in_tdata,
  // op
  input  logic                                                in_tuser,
  output logic                                                out_tvalid,
  input  logic                                                out_tready,
  // span_row, span_first, span_final, span_value
  output logic [bsr_pkg::byte_pad(3*DIM_BITS+bsr_pkg::VALUE_BITS)-1:0] out_tdata,
  // span_valid
  output logic                                                out_tuser,
  // line_done
  output logic                                                out_tlast,
  input  logic                                                cfg_psel,
  input  logic                                                cfg_penable,
  input  logic                                                cfg_pwrite,
  input  logic [2:0]                                          cfg_paddr,
  input  logic [31:0]                                         cfg_pwdata,
  output logic [31:0]                                         cfg_prdata,
  output logic                                                cfg_pready
);

  localparam int CMD_W = bsr_pkg::cmd_bits(COORD_BITS);
  localparam int OUT_W = bsr_pkg::byte_pad(3 * DIM_BITS + bsr_pkg::VALUE_BITS);
  localparam int CB    = bsr_pkg::CFG_BITS;

  logic [CB-1:0]                   img_width_r, img_width_nxt;
  logic [CB-1:0]                   img_height_r, img_height_nxt;
  logic                            cfg_wr;

  logic                            f_valid, f_ready, q_valid, q_ready;
  logic [CMD_W-1:0]                f_data, q_data;
  logic [DIM_BITS-1:0]             s_row, s_first, s_final;
  logic                            s_ok, s_done;
  logic [bsr_pkg::VALUE_BITS-1:0]  s_value;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    img_width_nxt  = img_width_r;
    img_height_nxt = img_height_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        bsr_pkg::REG_IMAGE_WIDTH:  img_width_nxt  = cfg_pwdata[CB-1:0];
        bsr_pkg::REG_IMAGE_HEIGHT: img_height_nxt = cfg_pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      bsr_pkg::REG_IMAGE_WIDTH:  cfg_prdata = 32'(img_width_r);
      bsr_pkg::REG_IMAGE_HEIGHT: cfg_prdata = 32'(img_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= bsr_pkg::DIM_RESET;
      img_height_r <= bsr_pkg::DIM_RESET;
    end else begin
      img_width_r  <= img_width_nxt;
      img_height_r <= img_height_nxt;
    end
  end

  bsr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_start_x (in_tdata[COORD_BITS-1:0]),
    .in_start_y (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_end_x   (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_end_y   (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .in_fill    (in_tdata[4*COORD_BITS+bsr_pkg::VALUE_BITS-1:4*COORD_BITS]),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_data     (f_data)
  );

  bsr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(bsr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  (f_data),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_data  (q_data)
  );

  bsr_walk #(
    .COORD_BITS(COORD_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_data         (q_data),
    .img_width      (img_width_r),
    .img_height     (img_height_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_row        (s_row),
    .out_first      (s_first),
    .out_final      (s_final),
    .out_span_valid (s_ok),
    .out_done       (s_done),
    .out_value      (s_value)
  );

  assign out_tdata = OUT_W'({s_value, s_final, s_first, s_row});
  assign out_tuser = s_ok;
  assign out_tlast = s_done;

  `BSR_ASSERT_IMPLIES(a_invalid_span_zero, clk, rst_n, out_tvalid && !out_tuser, s_row == '0 && s_first == '0 && s_final == '0, "invalid span carries coordinates")
  `BSR_ASSERT_IMPLIES(a_span_ordered, clk, rst_n, out_tvalid && out_tuser, s_first <= s_final, "span ends out of order")
  `BSR_ASSERT_IMPLIES(a_row_in_image, clk, rst_n, out_tvalid && out_tuser, 32'(s_row) < 32'(img_height_r), "valid span row outside image")
  `BSR_ASSERT_NEXT(a_cfg_height_write, clk, rst_n, cfg_wr && cfg_paddr[2] == bsr_pkg::REG_IMAGE_HEIGHT, img_height_r == $past(cfg_pwdata[CB-1:0]), "height register write lost")

endmodule

>>> tb/bresenham_span_rasterizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the line span rasterizer: queued stream traffic, span prediction
module bresenham_span_rasterizer_tb;

  localparam int CB             = bsr_pkg::COORD_BITS_DEF;
  localparam int DB             = bsr_pkg::DIM_BITS_DEF;
  localparam int VALUE_BITS     = bsr_pkg::VALUE_BITS;
  localparam int CFG_BITS       = bsr_pkg::CFG_BITS;
  localparam int IN_W           = bsr_pkg::byte_pad(4 * CB + VALUE_BITS);
  localparam int OUT_W          = bsr_pkg::byte_pad(3 * DB + VALUE_BITS);
  localparam int DIM_MAX        = 1 << DB;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 16;

  typedef struct {
    logic                   op;
    logic signed [CB-1:0]   sx;
    logic signed [CB-1:0]   sy;
    logic signed [CB-1:0]   ex;
    logic signed [CB-1:0]   ey;
    logic [VALUE_BITS-1:0]  fill;
  } line_item_t;

  typedef struct {
    logic [DB-1:0]          span_row;
    logic [DB-1:0]          span_first;
    logic [DB-1:0]          span_final;
    logic                   span_valid;
    logic                   line_done;
    logic [VALUE_BITS-1:0]  span_value;
  } span_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  bresenham_span_rasterizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  line_item_t stim_queue[$];
  span_t      span_expect[$];
  line_item_t bus_item;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  // walker state of the predictor
  logic signed [CB:0]   walk_major = '0;
  logic signed [CB:0]   walk_minor = '0;
  logic signed [CB:0]   walk_major_end = '0;
  logic signed [CB:0]   row_start_x = '0;
  logic signed [CB:0]   cur_row = '0;
  logic signed [CB+2:0] walk_err = '0;
  logic signed [CB+2:0] err_straight = '0;
  logic signed [CB+2:0] err_diag = '0;
  logic signed [1:0]    major_dir = '0;
  logic signed [1:0]    minor_dir = '0;
  logic                 is_steep = 1'b0;
  logic                 line_loaded = 1'b0;
  logic [VALUE_BITS-1:0] line_fill = '0;
  logic [CFG_BITS-1:0]  width_reg = bsr_pkg::DIM_RESET;
  logic [CFG_BITS-1:0]  height_reg = bsr_pkg::DIM_RESET;

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic span_t clip_span(int xa, int xb, int y, logic done);
    int    w;
    int    h;
    int    lo;
    int    hi;
    logic  ok;
    span_t s;
    w = (int'(width_reg) > DIM_MAX) ? DIM_MAX : int'(width_reg);
    h = (int'(height_reg) > DIM_MAX) ? DIM_MAX : int'(height_reg);
    lo = (xa < xb) ? xa : xb;
    hi = (xa < xb) ? xb : xa;
    ok = !(hi < 0 || lo >= w || y < 0 || y >= h);
    if (lo < 0) lo = 0;
    if (hi >= w) hi = w - 1;
    s.span_row   = ok ? DB'(y) : '0;
    s.span_first = ok ? DB'(lo) : '0;
    s.span_final = ok ? DB'(hi) : '0;
    s.span_valid = ok;
    s.line_done  = done;
    s.span_value = line_fill;
    return s;
  endfunction

  task automatic predict_item(line_item_t it);
    int    x0;
    int    y0;
    int    x1;
    int    y1;
    int    dx;
    int    dy;
    int    dmaj;
    int    dmin;
    int    last_x;
    int    cur_y;
    logic  finished;
    span_t s;
    if (it.op == bsr_pkg::OP_START) begin
      x0 = int'(it.sx);
      y0 = int'(it.sy);
      x1 = int'(it.ex);
      y1 = int'(it.ey);
      dx = x1 - x0;
      dy = y1 - y0;
      is_steep = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
      if (is_steep) begin
        walk_major = (CB+1)'(y0); walk_minor = (CB+1)'(x0); walk_major_end = (CB+1)'(y1);
        dmaj = dy; dmin = dx;
      end else begin
        walk_major = (CB+1)'(x0); walk_minor = (CB+1)'(y0); walk_major_end = (CB+1)'(x1);
        dmaj = dx; dmin = dy;
      end
      major_dir = (dmaj > 0) ? 2'sd1 : ((dmaj < 0) ? -2'sd1 : 2'sd0);
      minor_dir = (dmin > 0) ? 2'sd1 : ((dmin < 0) ? -2'sd1 : 2'sd0);
      if (dmaj < 0) dmaj = -dmaj;
      if (dmin < 0) dmin = -dmin;
      walk_err = (CB+3)'(2 * dmin - dmaj);
      err_straight = (CB+3)'(2 * dmin);
      err_diag = (CB+3)'(2 * (dmin - dmaj));
      line_fill = it.fill;
      row_start_x = (CB+1)'(x0);
      cur_row = (CB+1)'(y0);
      line_loaded = 1'b1;
    end else if (!line_loaded) begin
      s = '{default: '0};
      s.line_done = 1'b1;
      span_expect.push_back(s);
    end else begin
      finished = 1'b0;
      while (!finished) begin
        last_x = int'(is_steep ? walk_minor : walk_major);
        if (walk_major == walk_major_end) begin
          span_expect.push_back(clip_span(int'(row_start_x), last_x, int'(cur_row), 1'b1));
          line_loaded = 1'b0;
          finished = 1'b1;
        end else begin
          walk_major = walk_major + major_dir;
          if (walk_err < 0) begin
            walk_err = walk_err + err_straight;
          end else begin
            walk_err = walk_err + err_diag;
            walk_minor = walk_minor + minor_dir;
          end
          cur_y = int'(is_steep ? walk_major : walk_minor);
          if (cur_y != cur_row) begin
            span_expect.push_back(clip_span(int'(row_start_x), last_x, int'(cur_row), 1'b0));
            row_start_x = is_steep ? walk_minor : walk_major;
            cur_row = (CB+1)'(cur_y);
            finished = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic check_span(span_t got);
    span_t         want;
    logic [DB-1:0] want_f[6];
    logic [DB-1:0] got_f[6];
    string         names[6];
    if (span_expect.size() == 0) begin
      note_mismatch("span transaction with no expectation waiting");
      return;
    end
    want = span_expect.pop_front();
    names = '{"span_row", "span_first", "span_final", "span_valid", "line_done", "span_value"};
    want_f = '{want.span_row, want.span_first, want.span_final,
               DB'(want.span_valid), DB'(want.line_done), DB'(want.span_value)};
    got_f = '{got.span_row, got.span_first, got.span_final,
              DB'(got.span_valid), DB'(got.line_done), DB'(got.span_value)};
    for (int i = 0; i < 6; i++) begin
      if (got_f[i] !== want_f[i])
        note_mismatch($sformatf("%s: got %0h, expected %0h", names[i], got_f[i], want_f[i]));
    end
  endtask

  // driver: one transaction held until accepted, random sender gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_item(bus_item);
      if (!in_tvalid || in_tready) begin
        if (stim_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          bus_item = stim_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= bus_item.op;
          in_tdata <= {bus_item.fill, bus_item.ey, bus_item.ex, bus_item.sy, bus_item.sx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_span('{out_tdata[DB-1:0], out_tdata[2*DB-1:DB], out_tdata[3*DB-1:2*DB],
                   out_tuser, out_tlast, out_tdata[3*DB+VALUE_BITS-1:3*DB]});
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  task automatic add_start(int x0, int y0, int x1, int y1, int fill);
    line_item_t it;
    it.op = bsr_pkg::OP_START;
    it.sx = CB'(x0);
    it.sy = CB'(y0);
    it.ex = CB'(x1);
    it.ey = CB'(y1);
    it.fill = VALUE_BITS'(fill);
    stim_queue.push_back(it);
  endtask

  task automatic add_pull();
    line_item_t it;
    it.op = bsr_pkg::OP_PULL;
    it.sx = CB'($urandom());
    it.sy = CB'($urandom());
    it.ex = CB'($urandom());
    it.ey = CB'($urandom());
    it.fill = VALUE_BITS'($urandom());
    stim_queue.push_back(it);
  endtask

  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= ($urandom() & 32'hFFFF_E000) | (value & 32'h0000_1FFF);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == bsr_pkg::REG_IMAGE_WIDTH) width_reg = value[CFG_BITS-1:0];
    else height_reg = value[CFG_BITS-1:0];
  endtask

  task automatic read_check(logic idx, logic [CFG_BITS-1:0] want);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {{(32-CFG_BITS){1'b0}}, want})
      note_mismatch($sformatf("register %0d read %0h, expected %0h", idx, cfg_prdata, want));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (stim_queue.size() != 0 || in_tvalid || span_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly whole lines near the image, some cut short or overpulled, some noise
  task automatic add_random_items(int w, int h, int n);
    int ew;
    int eh;
    int count;
    int r;
    int x0;
    int y0;
    int x1;
    int y1;
    int a;
    int b;
    int pulls;
    ew = (w > DIM_MAX) ? DIM_MAX : w;
    eh = (h > DIM_MAX) ? DIM_MAX : h;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 82) begin
        if ($urandom_range(0, 4) == 0) begin
          x0 = int'($urandom_range(0, 65535)) - 32768;
          y0 = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          x0 = int'($urandom_range(0, ew + 12)) - 6;
          y0 = int'($urandom_range(0, eh + 8)) - 4;
        end
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        b = $urandom_range(0, a);
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
        if ($urandom_range(0, 1)) begin
          x1 = clamp_coord(x0 + b);
          y1 = clamp_coord(y0 + a);
        end else begin
          x1 = clamp_coord(x0 + a);
          y1 = clamp_coord(y0 + b);
        end
        add_start(x0, y0, x1, y1, $urandom_range(0, 255));
        pulls = ((y1 > y0) ? y1 - y0 : y0 - y1) + 1;
        r = $urandom_range(0, 99);
        if (r < 10) pulls = $urandom_range(0, pulls - 1);
        else if (r < 25) pulls++;
        repeat (pulls) add_pull();
        count += pulls + 1;
      end else if (r < 92) begin
        add_pull();
        count++;
      end else begin
        add_start(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
                  $urandom_range(0, 255));
        count++;
      end
    end
  endtask

  task automatic run_phase(int w, int h, int send_pct, int recv_pct, int n);
    write_reg(bsr_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bsr_pkg::REG_IMAGE_HEIGHT, h);
    read_check(bsr_pkg::REG_IMAGE_WIDTH, w[CFG_BITS-1:0]);
    read_check(bsr_pkg::REG_IMAGE_HEIGHT, h[CFG_BITS-1:0]);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
    add_random_items(w, h, n);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_check(bsr_pkg::REG_IMAGE_WIDTH, bsr_pkg::DIM_RESET);
    read_check(bsr_pkg::REG_IMAGE_HEIGHT, bsr_pkg::DIM_RESET);
    @(negedge clk);
    add_pull();                                       // nothing loaded yet
    add_start(10, 10, 10, 10, 8'h5A);                 // single point, then exhausted
    add_pull();
    add_pull();
    add_start(-32768, 7, 32767, 7, 255);              // full coordinate range, clipped
    add_pull();
    add_start(-32768, 0, 32767, 3, 0);
    repeat (4) add_pull();
    add_start(3, -2, 5, 2, 17);                       // steep, first rows above image
    repeat (5) add_pull();
    add_start(6, 5, 0, 1, 200);                       // walks backward in both axes
    repeat (5) add_pull();
    add_start(32767, 32767, 32767, 32767, 1);
    add_pull();
    add_start(-32768, -32768, -32768, -32768, 128);
    add_pull();
    drain();

    run_phase(8191, 5000, 64, 0, 120);
    run_phase(1, 1, 0, 64, 120);
    run_phase(0, 0, 17, 17, 100);
    for (int p = 0; p < 4; p++)
      run_phase($urandom_range(1, 64), $urandom_range(1, 64),
                (p == 1) ? 64 : ((p == 3) ? 17 : 0), (p == 2) ? 64 : ((p == 3) ? 17 : 0), 110);
    run_phase($urandom_range(0, 8191), $urandom_range(0, 8191), 17, 17, 100);
    run_phase(4096, 4096, 0, 0, 100);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
